// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Clocked assertion that holds at every edge, reset included.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

// ===== sv/btcp_pkg.sv =====
// ----------------------------------------------------------------------------
// btcp_pkg
// Constants and shared types of the byte to coefficient packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btcp_pkg;

	// Polynomial degree of one plaintext.
	localparam int POLY_DEGREE = 4096;

	// Field and state widths.
	localparam int BYTE_W   = 8;
	localparam int CB_W     = 6;
	localparam int COEFF_W  = 56;
	localparam int INDEX_W  = 12;
	localparam int BUF_W    = 63;
	localparam int CNT_W    = 6;

	// Output tdata: coeff_value then coeff_index, padded to whole bytes.
	localparam int OUT_FIELDS_W = COEFF_W + INDEX_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Configuration register reset value and legal range of the width.
	localparam logic [CB_W-1:0] CB_RESET = CB_W'(16);
	localparam logic [CB_W-1:0] CB_MIN   = CB_W'(1);
	localparam logic [CB_W-1:0] CB_MAX   = CB_W'(COEFF_W);

	// Highest pending bit count that a new byte may be placed above.
	localparam logic [CNT_W-1:0] CNT_LOAD_MAX = CNT_W'(BUF_W - BYTE_W);

	// Most coefficients that one item may produce.
	localparam int MAX_RESULTS = 8;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	// Last usable coefficient position, capped by the index width.
	localparam int LAST_SLOT_I = (POLY_DEGREE - 1 > (1 << INDEX_W) - 1) ?
		(1 << INDEX_W) - 1 : POLY_DEGREE - 1;
	localparam logic [INDEX_W-1:0] LAST_SLOT = INDEX_W'(LAST_SLOT_I);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // take the offered item into the bit buffer
		logic emit;   // load the output register with the low bits
		logic last;   // mark the emitted coefficient as the final one
		logic clear;  // return buffer, count and index to zero
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_emit;  // pending bits cover one coefficient
		logic exact;     // no bits remain after this coefficient
		logic next_can;  // another coefficient follows this one
		logic has_bits;  // some bits are pending
		logic end_flag;  // the current item closes a plaintext
		logic out_free;  // output register can take a coefficient
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/btcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// btcp_ctrl
// Controller: sequences the coefficients produced by one input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btcp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire btcp_pkg::sts_t sts,
	output btcp_pkg::cmd_t      cmd
);

	// State codes.
	localparam logic S_IDLE = 1'b0;
	localparam logic S_PACK = 1'b1;

	localparam logic [btcp_pkg::N_W-1:0] N_MAX  = btcp_pkg::N_W'(btcp_pkg::MAX_RESULTS);
	localparam logic [btcp_pkg::N_W-1:0] N_LAST = btcp_pkg::N_W'(btcp_pkg::MAX_RESULTS - 1);

	logic                       state_q;
	logic                       state_d;
	logic [btcp_pkg::N_W-1:0]   n_q;
	logic [btcp_pkg::N_W-1:0]   n_d;
	logic                       last_emit;

	// The input side is open only between items.
	assign s_tready = (state_q == S_IDLE);

	// Next-state and command decoding.
	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		n_d       = n_q;
		last_emit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					n_d      = '0;
					state_d  = S_PACK;
				end
			end
			S_PACK: begin
				if (sts.can_emit && (n_q != N_MAX)) begin
					// Regular coefficient out of the pending bits.
					if (sts.out_free) begin
						last_emit = sts.end_flag && (sts.exact || (n_q == N_LAST));
						cmd.emit  = 1'b1;
						cmd.last  = last_emit;
						cmd.clear = last_emit;
						n_d       = n_q + 1'b1;
						if (last_emit ||
						    (!sts.end_flag && (!sts.next_can || (n_q == N_LAST)))) begin
							state_d = S_IDLE;
						end
					end
				end else if (sts.end_flag) begin
					if (sts.has_bits && (n_q != N_MAX)) begin
						// Flush the leftover bits as the final coefficient.
						if (sts.out_free) begin
							cmd.emit  = 1'b1;
							cmd.last  = 1'b1;
							cmd.clear = 1'b1;
							state_d   = S_IDLE;
						end
					end else begin
						cmd.clear = 1'b1;
						state_d   = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/btcp_datapath.sv =====
// ----------------------------------------------------------------------------
// btcp_datapath
// Datapath: bit buffer, coefficient index, width register and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btcp_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration write
	input  wire logic                                cfg_valid,
	input  wire logic [btcp_pkg::CB_W-1:0]           cfg_data,
	// Input item payload
	input  wire logic [btcp_pkg::BYTE_W-1:0]         in_byte,
	input  wire logic                                in_end,
	// Output register
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [btcp_pkg::OUT_TDATA_W-1:0]         m_tdata,
	output logic                                     m_tlast,
	output logic                                     m_tuser,
	// Controller link
	input  wire btcp_pkg::cmd_t                      cmd,
	output btcp_pkg::sts_t                           sts
);

	logic [btcp_pkg::CB_W-1:0]    coeff_bits_q;
	logic [btcp_pkg::CB_W-1:0]    cb;
	logic [btcp_pkg::BUF_W-1:0]   buf_q;
	logic [btcp_pkg::CNT_W-1:0]   cnt_q;
	logic [btcp_pkg::INDEX_W-1:0] idx_q;
	logic                         full_q;
	logic                         end_q;
	logic [btcp_pkg::CNT_W-1:0]   cnt_load;
	logic [btcp_pkg::CNT_W-1:0]   rem;
	logic [btcp_pkg::COEFF_W-1:0] mask;
	logic [btcp_pkg::COEFF_W-1:0] value;
	logic                         at_lim;
	logic                         out_valid_q;
	logic [btcp_pkg::COEFF_W-1:0] out_value_q;
	logic [btcp_pkg::INDEX_W-1:0] out_index_q;
	logic                         out_last_q;
	logic                         out_ovf_q;

	// Coefficient width register; always ready for a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_bits_q <= btcp_pkg::CB_RESET;
		end else if (cfg_valid) begin
			coeff_bits_q <= cfg_data;
		end
	end

	// Effective width: zero acts as one, anything above the maximum as the maximum.
	always_comb begin
		priority if (coeff_bits_q == '0) begin
			cb = btcp_pkg::CB_MIN;
		end else if (coeff_bits_q > btcp_pkg::CB_MAX) begin
			cb = btcp_pkg::CB_MAX;
		end else begin
			cb = coeff_bits_q;
		end
	end

	// Status and coefficient value.
	assign cnt_load = (cnt_q > btcp_pkg::CNT_LOAD_MAX) ? btcp_pkg::CNT_LOAD_MAX : cnt_q;
	assign rem      = cnt_q - cb;
	assign mask     = ~({btcp_pkg::COEFF_W{1'b1}} << cb);
	assign value    = buf_q[btcp_pkg::COEFF_W-1:0] & mask;
	assign at_lim   = (idx_q >= btcp_pkg::LAST_SLOT);

	assign sts.can_emit = (cnt_q >= cb);
	assign sts.exact    = (rem == '0);
	assign sts.next_can = (rem >= cb);
	assign sts.has_bits = (cnt_q != '0);
	assign sts.end_flag = end_q;
	assign sts.out_free = !out_valid_q || m_tready;

	// Bit buffer, pending count and coefficient index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			full_q <= 1'b0;
			end_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				buf_q <= buf_q | (btcp_pkg::BUF_W'(in_byte) << cnt_load);
				cnt_q <= cnt_load + btcp_pkg::CNT_W'(btcp_pkg::BYTE_W);
				end_q <= in_end;
			end
			if (cmd.emit) begin
				buf_q  <= buf_q >> cb;
				cnt_q  <= rem;
				full_q <= full_q | at_lim;
				if (!at_lim) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.clear) begin
				buf_q  <= '0;
				cnt_q  <= '0;
				idx_q  <= '0;
				full_q <= 1'b0;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_value_q <= value;
			out_index_q <= idx_q;
			out_last_q  <= cmd.last;
			out_ovf_q   <= at_lim && full_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = btcp_pkg::OUT_TDATA_W'({out_index_q, out_value_q});
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

endmodule

`default_nettype wire

// ===== sv/byte_to_coefficient_packer_unit.sv =====
// ----------------------------------------------------------------------------
// byte_to_coefficient_packer_unit
// Packs a stream of bytes into coefficients of a configurable bit width.
// ----------------------------------------------------------------------------
//  Channel   Direction  Item
//  s_*       in         one byte, tlast closes the plaintext
//  m_*       out        one coefficient with index, tlast, overflow in tuser
//  cfg_*     in         coefficient width write
//
//  An item is taken in the idle state, and each coefficient it yields is
//  then produced in the packing state by the shared shifter, the flush of
//  leftover bits on a closing byte included; a byte that yields none still
//  passes through the packing state before the next byte is taken.
//  A stalled output holds the shifter until its register is taken.
//  Reset clears the buffer, index and output valid; the width returns to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_to_coefficient_packer_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [btcp_pkg::CB_W-1:0]           cfg_data,   // coeff_bits
	// Input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [btcp_pkg::BYTE_W-1:0]         s_tdata,    // data_byte
	input  wire logic                                s_tlast,    // plaintext_end
	// Output stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [btcp_pkg::OUT_TDATA_W-1:0]         m_tdata,    // coeff_value, coeff_index
	output logic                                     m_tlast,    // last_coeff
	output logic                                     m_tuser     // index_overflow
);

	btcp_pkg::cmd_t cmd;
	btcp_pkg::sts_t sts;

	// The width register takes a write at any time.
	assign cfg_ready = 1'b1;

	// Controller.
	btcp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	btcp_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_byte   (s_tdata),
		.in_end    (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== sv/btcp_checker.sv =====
// ----------------------------------------------------------------------------
// btcp_checker
// Port-level checks on the byte to coefficient packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module btcp_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_tvalid,
	input wire logic                                s_tready,
	input wire logic                                m_tvalid,
	input wire logic                                m_tready,
	input wire logic [btcp_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire logic                                m_tlast,
	input wire logic                                m_tuser
);

	logic                             s_take;
	logic                             m_stall;
	logic [btcp_pkg::OUT_TDATA_W+1:0] m_word;
	logic                             top_index;

	// Handshake terms and the offered coefficient as one word.
	assign s_take    = s_tvalid && s_tready;
	assign m_stall   = m_tvalid && !m_tready;
	assign m_word    = {m_tuser, m_tlast, m_tdata};
	assign top_index = (m_tdata[btcp_pkg::OUT_FIELDS_W-1:btcp_pkg::COEFF_W] == btcp_pkg::LAST_SLOT);

	// The input is not ready in the cycle after an item is taken.
	`ASSERT_RST(a_one_item_at_a_time, clk, arst_n, s_take |=> !s_tready, "input taken twice in a row")

	// A stalled coefficient stays offered unchanged.
	`ASSERT_RST(a_out_hold, clk, arst_n, m_stall |=> (m_tvalid && $stable(m_word)), "stalled coefficient changed")

	// An overflowing coefficient always carries the saturated position.
	`ASSERT_RST(a_ovf_saturates, clk, arst_n, (m_tvalid && m_tuser) |-> top_index, "overflow without saturated index")

	// Once reset has been seen at a clock edge, nothing is offered at the next one.
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !m_tvalid, "output valid after reset")

endmodule

bind byte_to_coefficient_packer_unit btcp_checker u_btcp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast),
	.m_tuser   (m_tuser)
);

`default_nettype wire
